/* src/segment_crossing_point_unit_defines.svh */
// assertion macros for the segment crossing point unit
`ifndef SEGMENT_CROSSING_POINT_UNIT_DEFINES_SVH
`define SEGMENT_CROSSING_POINT_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SCPU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCPU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define SCPU_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCPU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

/* src/scp_pkg.sv */
// shared widths, types and latencies of the segment crossing point unit
package scp_pkg;
    localparam int LON_W   = 29;
    localparam int LAT_W   = 28;
    localparam int DLON_W  = 30;
    localparam int DLAT_W  = 29;
    localparam int P_W     = 59;
    localparam int DEN_W   = 60;
    localparam int PP_W    = 61;
    localparam int NUM_W   = 90;
    localparam int SPLIT_W = 30;
    localparam int QB_W    = 30;
    localparam int QUO_W   = 31;
    localparam int DIV_LAT = QB_W + 3;
    localparam int FRONT_N = 6;

    typedef enum logic [1:0] {CS_GEN, CS_VERT, CS_NONE} case_t;

    typedef struct packed {
        case_t                    cs;
        logic signed [LON_W-1:0]  xlo;
        logic signed [LON_W-1:0]  xhi;
        logic signed [LAT_W-1:0]  ylo;
        logic signed [LAT_W-1:0]  yhi;
    } side_t;
endpackage

/* src/scp_div.sv */
// pipelined signed divider, one quotient bit per stage, flags quotients of 2^30 or more
module scp_div
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [scp_pkg::NUM_W-1:0]  num,
    input  logic signed [scp_pkg::DEN_W-1:0]  den,
    output logic signed [scp_pkg::QUO_W-1:0]  quo,
    output logic                              ovf
);
    import scp_pkg::*;

    logic [NUM_W-1:0]         na_reg;
    logic [NUM_W-1:0]         na_next;
    logic [DEN_W-1:0]         da_reg;
    logic [DEN_W-1:0]         da_next;
    logic                     ng_reg;
    logic                     ng_next;
    logic [DEN_W-1:0]         rem_reg [0:QB_W-1];
    logic [DEN_W-1:0]         rem_next [0:QB_W-2];
    logic [QB_W-1:0]          lo_reg [0:QB_W-1];
    logic [QB_W-1:0]          q_reg [0:QB_W];
    logic [QB_W-1:0]          q_next [0:QB_W-1];
    logic [DEN_W-1:0]         d_reg [0:QB_W-1];
    logic                     neg_reg [0:QB_W];
    logic                     ov_reg [0:QB_W];
    logic [DEN_W+1:0]         diff [0:QB_W-1];
    logic signed [QUO_W-1:0]  quo_reg;
    logic signed [QUO_W-1:0]  quo_next;
    logic signed [QUO_W-1:0]  mag;
    logic                     ovf_reg;

    always_comb
    begin
        na_next = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        da_next = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        ng_next = num[NUM_W-1] ^ den[DEN_W-1];
    end

    // restoring step: shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        for (int k = 0; k < QB_W; k++)
        begin
            diff[k] = {1'b0, rem_reg[k], lo_reg[k][QB_W-1]} - {2'b00, d_reg[k]};
            q_next[k] = {q_reg[k][QB_W-2:0], !diff[k][DEN_W+1]};
        end
        for (int k = 0; k < QB_W - 1; k++)
        begin
            if (!diff[k][DEN_W+1])
            begin
                rem_next[k] = diff[k][DEN_W-1:0];
            end
            else
            begin
                rem_next[k] = {rem_reg[k][DEN_W-2:0], lo_reg[k][QB_W-1]};
            end
        end
    end

    always_comb
    begin
        mag      = $signed({1'b0, q_reg[QB_W]});
        quo_next = neg_reg[QB_W] ? -mag : mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_reg     <= na_next;
            da_reg     <= da_next;
            ng_reg     <= ng_next;
            rem_reg[0] <= na_reg[NUM_W-1:QB_W];
            lo_reg[0]  <= na_reg[QB_W-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= da_reg;
            neg_reg[0] <= ng_reg;
            ov_reg[0]  <= (na_reg[NUM_W-1:QB_W] >= da_reg);
            for (int k = 0; k < QB_W - 1; k++)
            begin
                rem_reg[k+1] <= rem_next[k];
                lo_reg[k+1]  <= {lo_reg[k][QB_W-2:0], 1'b0};
                d_reg[k+1]   <= d_reg[k];
            end
            for (int k = 0; k < QB_W; k++)
            begin
                q_reg[k+1]   <= q_next[k];
                neg_reg[k+1] <= neg_reg[k];
                ov_reg[k+1]  <= ov_reg[k];
            end
            quo_reg <= quo_next;
            ovf_reg <= ov_reg[QB_W];
        end
    end

    assign quo = quo_reg;
    assign ovf = ovf_reg;
endmodule

/* src/segment_crossing_point_unit.sv */
// segment crossing point unit: top level with product front end and range test
// throughput: one item per cycle while the output is not stalled; the two 33-stage
// dividers (one quotient bit per stage) set the depth, every stage holds a different item
// a stalled output holds the whole pipeline in place
// reset clears the valid bits only, the data registers are left as they are
`include "segment_crossing_point_unit_defines.svh"
module segment_crossing_point_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [scp_pkg::LON_W-1:0]  a_start_lon,
    input  logic signed [scp_pkg::LAT_W-1:0]  a_start_lat,
    input  logic signed [scp_pkg::LON_W-1:0]  a_end_lon,
    input  logic signed [scp_pkg::LAT_W-1:0]  a_end_lat,
    input  logic signed [scp_pkg::LON_W-1:0]  b_start_lon,
    input  logic signed [scp_pkg::LAT_W-1:0]  b_start_lat,
    input  logic signed [scp_pkg::LON_W-1:0]  b_end_lon,
    input  logic signed [scp_pkg::LAT_W-1:0]  b_end_lat,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              crosses,
    output logic signed [scp_pkg::LON_W-1:0]  cross_lon,
    output logic signed [scp_pkg::LAT_W-1:0]  cross_lat
);
    import scp_pkg::*;

    localparam int VLD_N = FRONT_N + DIV_LAT;

    typedef struct packed {
        logic signed [LON_W-1:0]   x1;
        logic signed [LON_W-1:0]   x2;
        logic signed [LON_W-1:0]   u1;
        logic signed [LON_W-1:0]   u2;
        logic signed [LAT_W-1:0]   y1;
        logic signed [LAT_W-1:0]   y2;
        logic signed [LAT_W-1:0]   v1;
        logic signed [LAT_W-1:0]   v2;
        logic signed [DLON_W-1:0]  dx;
        logic signed [DLON_W-1:0]  du;
        logic signed [DLON_W-1:0]  ex;
        logic signed [DLAT_W-1:0]  dy;
        logic signed [DLAT_W-1:0]  dv;
        logic signed [DLAT_W-1:0]  ey;
    } s1_t;

    typedef struct packed {
        logic signed [P_W-1:0]     p_dxdv;
        logic signed [P_W-1:0]     p_dydu;
        logic signed [P_W-1:0]     p_exdv;
        logic signed [P_W-1:0]     p_eydu;
        logic signed [P_W-1:0]     vp1;
        logic signed [P_W-1:0]     vp2;
        logic signed [LON_W-1:0]   x1;
        logic signed [LAT_W-1:0]   y1;
        logic signed [DLON_W-1:0]  dx;
        logic signed [DLAT_W-1:0]  dy;
        logic signed [LON_W-1:0]   vxi;
        logic signed [DLON_W-1:0]  vd;
    } s2_t;

    typedef struct packed {
        logic signed [DEN_W-1:0]   dn;
        logic signed [DEN_W-1:0]   num;
        logic signed [DEN_W-1:0]   vn;
        logic signed [LON_W-1:0]   x1;
        logic signed [LAT_W-1:0]   y1;
        logic signed [DLON_W-1:0]  dx;
        logic signed [DLAT_W-1:0]  dy;
        logic signed [LON_W-1:0]   vxi;
        logic signed [DLON_W-1:0]  vd;
    } s3_t;

    typedef struct packed {
        logic signed [PP_W-1:0]    pxh;
        logic signed [PP_W-1:0]    pxl;
        logic signed [PP_W-1:0]    qxh;
        logic signed [PP_W-1:0]    qxl;
        logic signed [PP_W-1:0]    pyh;
        logic signed [PP_W-1:0]    pyl;
        logic signed [PP_W-1:0]    qyh;
        logic signed [PP_W-1:0]    qyl;
        logic signed [DEN_W-1:0]   dn;
        logic signed [DEN_W-1:0]   vn;
        logic signed [LON_W-1:0]   vxi;
        logic signed [DLON_W-1:0]  vd;
    } s4_t;

    typedef struct packed {
        logic signed [PP_W-1:0]    xh;
        logic signed [PP_W:0]      xl;
        logic signed [PP_W-1:0]    yh;
        logic signed [PP_W:0]      yl;
        logic signed [DEN_W-1:0]   dn;
        logic signed [DEN_W-1:0]   vn;
        logic signed [LON_W-1:0]   vxi;
        logic signed [DLON_W-1:0]  vd;
    } s5_t;

    logic                     en;
    logic [VLD_N:1]           vld_reg;
    logic [VLD_N:1]           vld_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;

    s1_t                      s1_reg, s1_next;
    s2_t                      s2_reg, s2_next;
    s3_t                      s3_reg, s3_next;
    s4_t                      s4_reg, s4_next;
    s5_t                      s5_reg, s5_next;
    side_t                    sd2_reg, sd2_next;
    side_t                    sd3_reg;
    side_t                    sd4_reg, sd4_next;
    side_t                    sd5_reg;
    side_t                    sd_reg [0:DIV_LAT];

    logic signed [NUM_W-1:0]  xn_reg, xn_next;
    logic signed [NUM_W-1:0]  yn_reg, yn_next;
    logic signed [DEN_W-1:0]  xd_reg, xd_next;
    logic signed [DEN_W-1:0]  yd_reg, yd_next;

    logic                     vert_a;
    logic signed [LAT_W-1:0]  vy;
    logic signed [DLON_W-1:0] vd;
    logic signed [DLAT_W-1:0] vs;
    logic signed [DLON_W-1:0] vex;
    logic signed [LON_W-1:0]  ax_lo, ax_hi, bx_lo, bx_hi;
    logic signed [LAT_W-1:0]  ay_lo, ay_hi, by_lo, by_hi;
    logic signed [SPLIT_W-1:0] dn_hi, num_hi;
    logic signed [SPLIT_W:0]  dn_lo, num_lo;
    logic signed [NUM_W-1:0]  nx, ny;

    logic signed [QUO_W-1:0]  qx, qy;
    logic                     ovx, ovy;
    logic                     hit;
    side_t                    sd_last;
    logic                     crosses_reg, crosses_next;
    logic signed [LON_W-1:0]  cross_lon_reg, cross_lon_next;
    logic signed [LAT_W-1:0]  cross_lat_reg, cross_lat_next;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // stage 1: differences
    always_comb
    begin
        s1_next.x1 = a_start_lon;
        s1_next.x2 = a_end_lon;
        s1_next.u1 = b_start_lon;
        s1_next.u2 = b_end_lon;
        s1_next.y1 = a_start_lat;
        s1_next.y2 = a_end_lat;
        s1_next.v1 = b_start_lat;
        s1_next.v2 = b_end_lat;
        s1_next.dx = DLON_W'(a_end_lon) - DLON_W'(a_start_lon);
        s1_next.du = DLON_W'(b_end_lon) - DLON_W'(b_start_lon);
        s1_next.ex = DLON_W'(b_start_lon) - DLON_W'(a_start_lon);
        s1_next.dy = DLAT_W'(a_end_lat) - DLAT_W'(a_start_lat);
        s1_next.dv = DLAT_W'(b_end_lat) - DLAT_W'(b_start_lat);
        s1_next.ey = DLAT_W'(b_start_lat) - DLAT_W'(a_start_lat);
    end

    // stage 2: cross products, vertical-line numerator, bounding box
    always_comb
    begin
        vert_a = (s1_reg.dx == '0);
        vy     = vert_a ? s1_reg.v1 : s1_reg.y1;
        vd     = vert_a ? s1_reg.du : s1_reg.dx;
        vs     = vert_a ? s1_reg.dv : s1_reg.dy;
        vex    = vert_a ? -s1_reg.ex : s1_reg.ex;

        s2_next.p_dxdv = P_W'(s1_reg.dx) * P_W'(s1_reg.dv);
        s2_next.p_dydu = P_W'(s1_reg.dy) * P_W'(s1_reg.du);
        s2_next.p_exdv = P_W'(s1_reg.ex) * P_W'(s1_reg.dv);
        s2_next.p_eydu = P_W'(s1_reg.ey) * P_W'(s1_reg.du);
        s2_next.vp1    = P_W'(vy) * P_W'(vd);
        s2_next.vp2    = P_W'(vs) * P_W'(vex);
        s2_next.x1     = s1_reg.x1;
        s2_next.y1     = s1_reg.y1;
        s2_next.dx     = s1_reg.dx;
        s2_next.dy     = s1_reg.dy;
        s2_next.vxi    = vert_a ? s1_reg.x1 : s1_reg.u1;
        s2_next.vd     = vd;

        ax_lo = (s1_reg.x1 < s1_reg.x2) ? s1_reg.x1 : s1_reg.x2;
        ax_hi = (s1_reg.x1 < s1_reg.x2) ? s1_reg.x2 : s1_reg.x1;
        bx_lo = (s1_reg.u1 < s1_reg.u2) ? s1_reg.u1 : s1_reg.u2;
        bx_hi = (s1_reg.u1 < s1_reg.u2) ? s1_reg.u2 : s1_reg.u1;
        ay_lo = (s1_reg.y1 < s1_reg.y2) ? s1_reg.y1 : s1_reg.y2;
        ay_hi = (s1_reg.y1 < s1_reg.y2) ? s1_reg.y2 : s1_reg.y1;
        by_lo = (s1_reg.v1 < s1_reg.v2) ? s1_reg.v1 : s1_reg.v2;
        by_hi = (s1_reg.v1 < s1_reg.v2) ? s1_reg.v2 : s1_reg.v1;
        sd2_next.xlo = (ax_lo > bx_lo) ? ax_lo : bx_lo;
        sd2_next.xhi = (ax_hi < bx_hi) ? ax_hi : bx_hi;
        sd2_next.ylo = (ay_lo > by_lo) ? ay_lo : by_lo;
        sd2_next.yhi = (ay_hi < by_hi) ? ay_hi : by_hi;
        if (vert_a && s1_reg.du == '0)
        begin
            sd2_next.cs = CS_NONE;
        end
        else if (vert_a || s1_reg.du == '0)
        begin
            sd2_next.cs = CS_VERT;
        end
        else
        begin
            sd2_next.cs = CS_GEN;
        end
    end

    // stage 3: denominator and numerators
    always_comb
    begin
        s3_next.dn  = DEN_W'(s2_reg.p_dxdv) - DEN_W'(s2_reg.p_dydu);
        s3_next.num = DEN_W'(s2_reg.p_exdv) - DEN_W'(s2_reg.p_eydu);
        s3_next.vn  = DEN_W'(s2_reg.vp1) + DEN_W'(s2_reg.vp2);
        s3_next.x1  = s2_reg.x1;
        s3_next.y1  = s2_reg.y1;
        s3_next.dx  = s2_reg.dx;
        s3_next.dy  = s2_reg.dy;
        s3_next.vxi = s2_reg.vxi;
        s3_next.vd  = s2_reg.vd;
    end

    // stage 4: partial products of the wide dividends, halves of dn and num
    always_comb
    begin
        dn_hi  = $signed(s3_reg.dn[DEN_W-1:SPLIT_W]);
        dn_lo  = $signed({1'b0, s3_reg.dn[SPLIT_W-1:0]});
        num_hi = $signed(s3_reg.num[DEN_W-1:SPLIT_W]);
        num_lo = $signed({1'b0, s3_reg.num[SPLIT_W-1:0]});
        s4_next.pxh = PP_W'(s3_reg.x1) * PP_W'(dn_hi);
        s4_next.pxl = PP_W'(s3_reg.x1) * PP_W'(dn_lo);
        s4_next.qxh = PP_W'(s3_reg.dx) * PP_W'(num_hi);
        s4_next.qxl = PP_W'(s3_reg.dx) * PP_W'(num_lo);
        s4_next.pyh = PP_W'(s3_reg.y1) * PP_W'(dn_hi);
        s4_next.pyl = PP_W'(s3_reg.y1) * PP_W'(dn_lo);
        s4_next.qyh = PP_W'(s3_reg.dy) * PP_W'(num_hi);
        s4_next.qyl = PP_W'(s3_reg.dy) * PP_W'(num_lo);
        s4_next.dn  = s3_reg.dn;
        s4_next.vn  = s3_reg.vn;
        s4_next.vxi = s3_reg.vxi;
        s4_next.vd  = s3_reg.vd;
        sd4_next    = sd3_reg;
        // parallel or collinear lines
        if (sd3_reg.cs == CS_GEN && s3_reg.dn == '0)
        begin
            sd4_next.cs = CS_NONE;
        end
    end

    // stage 5: high and low sums
    always_comb
    begin
        s5_next.xh  = s4_reg.pxh + s4_reg.qxh;
        s5_next.xl  = (PP_W+1)'(s4_reg.pxl) + (PP_W+1)'(s4_reg.qxl);
        s5_next.yh  = s4_reg.pyh + s4_reg.qyh;
        s5_next.yl  = (PP_W+1)'(s4_reg.pyl) + (PP_W+1)'(s4_reg.qyl);
        s5_next.dn  = s4_reg.dn;
        s5_next.vn  = s4_reg.vn;
        s5_next.vxi = s4_reg.vxi;
        s5_next.vd  = s4_reg.vd;
    end

    // stage 6: full dividends, divider operands per case
    always_comb
    begin
        nx = (NUM_W'(s5_reg.xh) <<< SPLIT_W) + NUM_W'(s5_reg.xl);
        ny = (NUM_W'(s5_reg.yh) <<< SPLIT_W) + NUM_W'(s5_reg.yl);
        case (sd5_reg.cs)
            CS_GEN:
            begin
                xn_next = nx;
                yn_next = ny;
                xd_next = s5_reg.dn;
                yd_next = s5_reg.dn;
            end
            CS_VERT:
            begin
                // the vertical line fixes the longitude, divide by one
                xn_next = NUM_W'(s5_reg.vxi);
                yn_next = NUM_W'(s5_reg.vn);
                xd_next = DEN_W'(1);
                yd_next = DEN_W'(s5_reg.vd);
            end
            default:
            begin
                xn_next = '0;
                yn_next = '0;
                xd_next = DEN_W'(1);
                yd_next = DEN_W'(1);
            end
        endcase
    end

    scp_div u_div_x
    (
        .clk (clk),
        .en  (en),
        .num (xn_reg),
        .den (xd_reg),
        .quo (qx),
        .ovf (ovx)
    );

    scp_div u_div_y
    (
        .clk (clk),
        .en  (en),
        .num (yn_reg),
        .den (yd_reg),
        .quo (qy),
        .ovf (ovy)
    );

    // final stage: inclusive range test on the truncated point
    always_comb
    begin
        sd_last = sd_reg[DIV_LAT];
        hit = (sd_last.cs != CS_NONE) && !ovx && !ovy
            && (qx >= QUO_W'($signed(sd_last.xlo))) && (qx <= QUO_W'($signed(sd_last.xhi)))
            && (qy >= QUO_W'($signed(sd_last.ylo))) && (qy <= QUO_W'($signed(sd_last.yhi)));
        crosses_next   = hit;
        cross_lon_next = hit ? qx[LON_W-1:0] : '0;
        cross_lat_next = hit ? qy[LAT_W-1:0] : '0;
        vld_next       = {vld_reg[VLD_N-1:1], in_valid};
        out_valid_next = vld_reg[VLD_N];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg        <= s1_next;
            s2_reg        <= s2_next;
            sd2_reg       <= sd2_next;
            s3_reg        <= s3_next;
            sd3_reg       <= sd2_reg;
            s4_reg        <= s4_next;
            sd4_reg       <= sd4_next;
            s5_reg        <= s5_next;
            sd5_reg       <= sd4_reg;
            xn_reg        <= xn_next;
            yn_reg        <= yn_next;
            xd_reg        <= xd_next;
            yd_reg        <= yd_next;
            sd_reg[0]     <= sd5_reg;
            for (int k = 1; k <= DIV_LAT; k++)
            begin
                sd_reg[k] <= sd_reg[k-1];
            end
            crosses_reg   <= crosses_next;
            cross_lon_reg <= cross_lon_next;
            cross_lat_reg <= cross_lat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign crosses   = crosses_reg;
    assign cross_lon = cross_lon_reg;
    assign cross_lat = cross_lat_reg;

    `SCPU_ASSERT(a_zero_no_cross, clk, rst_n, out_valid && !crosses |-> cross_lon == '0 && cross_lat == '0, "coordinates not zero without crossing")
    `SCPU_ASSERT_NEXT(a_enter, clk, rst_n, in_valid && !in_stall, vld_reg[1], "accepted item lost at entry")
    `SCPU_ASSERT_NEXT(a_leave, clk, rst_n, vld_reg[VLD_N] && en, out_valid, "item lost at output stage")
    `SCPU_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid, "stalled result dropped")
endmodule

/* bench/segment_crossing_point_checker.sv */
// checker for the segment crossing point unit: watches both channels, predicts and compares
module segment_crossing_point_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic signed [scp_pkg::LON_W-1:0]  a_start_lon,
    input  logic signed [scp_pkg::LAT_W-1:0]  a_start_lat,
    input  logic signed [scp_pkg::LON_W-1:0]  a_end_lon,
    input  logic signed [scp_pkg::LAT_W-1:0]  a_end_lat,
    input  logic signed [scp_pkg::LON_W-1:0]  b_start_lon,
    input  logic signed [scp_pkg::LAT_W-1:0]  b_start_lat,
    input  logic signed [scp_pkg::LON_W-1:0]  b_end_lon,
    input  logic signed [scp_pkg::LAT_W-1:0]  b_end_lat,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              crosses,
    input  logic signed [scp_pkg::LON_W-1:0]  cross_lon,
    input  logic signed [scp_pkg::LAT_W-1:0]  cross_lat,
    output int                                pending,
    output int                                failures
);
    timeunit 1ns;
    timeprecision 1ps;
    import scp_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic                     crosses;
        logic signed [LON_W-1:0]  lon;
        logic signed [LAT_W-1:0]  lat;
    } crossing_t;

    crossing_t crossing_q[$];

    function automatic logic in_span(wide_t p, wide_t e0, wide_t e1);
        wide_t lo;
        wide_t hi;
        lo = (e0 < e1) ? e0 : e1;
        hi = (e0 < e1) ? e1 : e0;
        return (p >= lo) && (p <= hi);
    endfunction

    function automatic crossing_t crossing_point(wide_t x1, wide_t y1, wide_t x2, wide_t y2,
                                                 wide_t u1, wide_t v1, wide_t u2, wide_t v2);
        wide_t dx, dy, du, dv, dn, num, xi, yi;
        wide_t qlim;
        logic ok;
        crossing_t r;
        dx = x2 - x1;
        dy = y2 - y1;
        du = u2 - u1;
        dv = v2 - v1;
        xi = '0;
        yi = '0;
        ok = 1'b1;
        qlim = wide_t'(1) <<< 62;
        if (dx != '0 && du != '0)
        begin
            dn = dx * dv - dy * du;
            if (dn == '0)
            begin
                ok = 1'b0;
            end
            else
            begin
                num = (u1 - x1) * dv - (v1 - y1) * du;
                xi = (x1 * dn + num * dx) / dn;
                yi = (y1 * dn + num * dy) / dn;
                // quotients of magnitude 2^62 or more give no crossing
                if (xi >= qlim || xi <= -qlim || yi >= qlim || yi <= -qlim)
                begin
                    ok = 1'b0;
                end
            end
        end
        else if (dx != '0)
        begin
            xi = u1;
            yi = (y1 * dx + dy * (u1 - x1)) / dx;
        end
        else if (du != '0)
        begin
            xi = x1;
            yi = (v1 * du + dv * (x1 - u1)) / du;
        end
        else
        begin
            ok = 1'b0;
        end
        if (ok)
        begin
            ok = in_span(xi, x1, x2) && in_span(xi, u1, u2) &&
                 in_span(yi, y1, y2) && in_span(yi, v1, v2);
        end
        r.crosses = ok;
        r.lon = ok ? xi[LON_W-1:0] : '0;
        r.lat = ok ? yi[LAT_W-1:0] : '0;
        return r;
    endfunction

    always @(posedge clk)
    begin
        crossing_t exp_r;
        if (!rst_n)
        begin
            failures <= 0;
            crossing_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (crossing_q.size() == 0)
                begin
                    failures <= failures + 1;
                    if (failures < 10)
                    begin
                        $display("%0t: result with none expected: crosses %0d lon %0d lat %0d",
                                 $realtime, crosses, cross_lon, cross_lat);
                    end
                end
                else
                begin
                    exp_r = crossing_q.pop_front();
                    if (exp_r.crosses !== crosses || exp_r.lon !== cross_lon ||
                        exp_r.lat !== cross_lat)
                    begin
                        failures <= failures + 1;
                        if (failures < 10)
                        begin
                            $display("%0t: mismatch: expected crosses %0d lon %0d lat %0d,",
                                     $realtime, exp_r.crosses, exp_r.lon, exp_r.lat);
                            $display("    got crosses %0d lon %0d lat %0d",
                                     crosses, cross_lon, cross_lat);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                crossing_q.push_back(crossing_point(
                    wide_t'(a_start_lon), wide_t'(a_start_lat),
                    wide_t'(a_end_lon), wide_t'(a_end_lat),
                    wide_t'(b_start_lon), wide_t'(b_start_lat),
                    wide_t'(b_end_lon), wide_t'(b_end_lat)));
            end
        end
        pending = crossing_q.size();
    end
endmodule

/* bench/segment_crossing_point_unit_tb.sv */
// testbench top for the segment crossing point unit: stimulus, flow control and verdict
module segment_crossing_point_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import scp_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam longint LON_MAX  = 188743680;
    localparam longint LAT_MAX  = 94371840;
    localparam longint ONE      = 1;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [LON_W-1:0] a_start_lon, a_end_lon, b_start_lon, b_end_lon;
    logic signed [LAT_W-1:0] a_start_lat, a_end_lat, b_start_lat, b_end_lat;
    logic out_valid;
    logic out_stall;
    logic crosses;
    logic signed [LON_W-1:0] cross_lon;
    logic signed [LAT_W-1:0] cross_lat;
    int pending;
    int failures;
    int cycles = 0;
    logic quiet;

    segment_crossing_point_unit dut (.*);
    segment_crossing_point_checker chk (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int idle_draw();
        return quiet ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic longint pick(longint lim);
        return longint'($urandom_range(0, 32'(2 * lim))) - lim;
    endfunction

    task automatic send_segments(longint x1, longint y1, longint x2, longint y2,
                                 longint u1, longint v1, longint u2, longint v2);
        int gap;
        logic taken;
        gap = idle_draw();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        a_start_lon <= x1[LON_W-1:0];
        a_start_lat <= y1[LAT_W-1:0];
        a_end_lon   <= x2[LON_W-1:0];
        a_end_lat   <= y2[LAT_W-1:0];
        b_start_lon <= u1[LON_W-1:0];
        b_start_lat <= v1[LAT_W-1:0];
        b_end_lon   <= u2[LON_W-1:0];
        b_end_lat   <= v2[LAT_W-1:0];
        in_valid    <= 1'b1;
        do
        begin
            @(posedge clk);
            taken = !in_stall;
            @(negedge clk);
        end
        while (!taken);
    endtask

    // segments through a common point, both lines passing through it
    task automatic send_through_point(int span);
        longint px, py, ax, ay, bx, by, r0, r1, r2, r3;
        px = pick(ONE <<< 26);
        py = pick(ONE <<< 25);
        ax = pick(ONE <<< span);
        ay = pick(ONE <<< span);
        bx = pick(ONE <<< span);
        by = pick(ONE <<< span);
        r0 = longint'($urandom_range(0, 1024));
        r1 = longint'($urandom_range(0, 1024));
        r2 = longint'($urandom_range(0, 1024));
        r3 = longint'($urandom_range(0, 1024));
        if ($urandom_range(0, 3) == 0)
        begin
            ax = 0;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            bx = 0;
        end
        send_segments(px - ax * r0, py - ay * r0, px + ax * r1, py + ay * r1,
                      px - bx * r2, py - by * r2, px + bx * r3, py + by * r3);
    endtask

    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            n = idle_draw();
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid && rst_n));
        end
    end

    initial
    begin
        longint x, y, k;
        int kind;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        quiet = 1'b0;
        {a_start_lon, a_start_lat, a_end_lon, a_end_lat} = '0;
        {b_start_lon, b_start_lat, b_end_lon, b_end_lat} = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // simple x crossing, extremes of the range, touching ends
        send_segments(-100, -100, 100, 100, -100, 100, 100, -100);
        send_segments(-LON_MAX, -LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, -LAT_MAX);
        send_segments(LON_MAX, LAT_MAX, -LON_MAX, -LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX, LAT_MAX);
        send_segments(0, 0, 10, 10, 10, 10, 20, 0);
        // a vertical only, b vertical only, b a single point, both vertical
        send_segments(5, -50, 5, 50, -20, 3, 30, 8);
        send_segments(-20, 3, 30, 8, 5, -50, 5, 50);
        send_segments(0, 0, 10, 10, 5, 5, 5, 5);
        send_segments(0, 0, 10, 10, 4, 5, 4, 5);
        send_segments(5, -50, 5, 50, 5, -10, 5, 10);
        // parallel and collinear
        send_segments(0, 0, 10, 10, 0, 1, 10, 11);
        send_segments(0, 0, 10, 10, 5, 5, 15, 15);
        // truncation toward zero on either sign
        send_segments(0, 0, 3, 1, 1, -5, 1, 5);
        send_segments(0, 0, -3, -1, -1, -5, -1, 5);
        send_segments(-7, 3, 11, -4, -2, -9, 5, 13);
        // all zeros, all ones and out-of-range bit patterns
        send_segments(0, 0, 0, 0, 0, 0, 0, 0);
        send_segments(-1, -1, -1, -1, -1, -1, -1, -1);
        send_segments(-(ONE <<< 28), -(ONE <<< 27), (ONE <<< 28) - 1, (ONE <<< 27) - 1,
                      -(ONE <<< 28), (ONE <<< 27) - 1, (ONE <<< 28) - 1, -(ONE <<< 27));
        send_segments((ONE <<< 28) - 1, 1, -(ONE <<< 28), 0,
                      3, (ONE <<< 27) - 1, 2, -(ONE <<< 27));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 250 == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            kind = int'($urandom_range(0, 9));
            if (kind <= 4)
            begin
                send_through_point(($urandom_range(0, 7) == 0) ? 14 :
                                   int'($urandom_range(1, 10)));
            end
            else if (kind == 5)
            begin
                x = pick(LON_MAX);
                send_segments(x, pick(LAT_MAX), x, pick(LAT_MAX),
                              pick(LON_MAX), pick(LAT_MAX), pick(LON_MAX), pick(LAT_MAX));
            end
            else if (kind == 6)
            begin
                x = pick(LON_MAX);
                send_segments(pick(LON_MAX), pick(LAT_MAX), pick(LON_MAX), pick(LAT_MAX),
                              x, pick(LAT_MAX), x, pick(LAT_MAX));
            end
            else if (kind == 7)
            begin
                // parallel lines sharing a direction
                x = pick(ONE <<< 12);
                y = pick(ONE <<< 12);
                k = pick(ONE <<< 14);
                send_segments(k, k, k + x * 8, k + y * 8, -k, k, -k + x * 3, k + y * 3);
            end
            else if (kind == 8)
            begin
                send_segments(pick(LON_MAX), pick(LAT_MAX), pick(LON_MAX), pick(LAT_MAX),
                              pick(LON_MAX), pick(LAT_MAX), pick(LON_MAX), pick(LAT_MAX));
            end
            else
            begin
                send_segments(longint'($urandom), longint'($urandom),
                              longint'($urandom), longint'($urandom),
                              longint'($urandom), longint'($urandom),
                              longint'($urandom), longint'($urandom));
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
